// ===== sv/oaht_pkg.sv =====
// Shared types, codes and constants of the open-addressing hash table unit.
`default_nettype none
package oaht_pkg;

	// default slot count
	localparam int SLOTS_DEF = 16;

	// fractional part of the golden ratio in unsigned 0.32 fixed point
	localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;

	// command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// slot marks
	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_USED    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [30:0] key;
		logic [31:0] value;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] found_value;
		logic [3:0]  slot_index;
	} response_t;

	typedef struct packed {
		logic [1:0]  mark;
		logic [30:0] key;
		logic [31:0] payload;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic clr;   // clearing pass, one slot per cycle
		logic load;  // capture the request word
		logic hash;  // golden-ratio product
		logic home;  // scale to home slot, early outcomes
		logic probe; // linear probe step
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last; // last slot being cleared
		logic early;    // command resolved without probing
		logic finish;   // probe sequence resolved
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/oaht_ctrl.sv =====
// Sequencing state machine of the hash table unit.
`default_nettype none
module oaht_ctrl
	import oaht_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	output ctl_cmd_t      ctl,
	input  wire dp_stat_t stat
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_HASH  = 5'b00100,
		S_HOME  = 5'b01000,
		S_PROBE = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		busy    = 1'b1;
		case (state_q)
			S_CLEAR: begin
				ctl.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				ctl.hash = 1'b1;
				state_d  = S_HOME;
			end
			S_HOME: begin
				ctl.home = 1'b1;
				state_d  = stat.early ? S_IDLE : S_PROBE;
			end
			S_PROBE: begin
				ctl.probe = 1'b1;
				if (stat.finish) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/oaht_dp.sv =====
// Datapath of the hash table unit: hashing, slot memory, probe evaluation, result.
`default_nettype none
module oaht_dp
	import oaht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire ctl_cmd_t ctl,
	input  wire request_t req,
	output dp_stat_t      stat,
	output logic          done,
	output response_t     resp
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int PRD_W = 32 + CNT_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SLOTS - 1);

	// captured request
	logic [1:0]       cmd_q;
	logic [30:0]      key_q;
	logic [31:0]      value_q;
	// hashing
	logic [31:0]      frac_s1;
	logic [PRD_W-1:0] scaled;
	// probing
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] clr_ptr_q;
	logic [IDX_W-1:0] eval_addr_s1;
	logic             rd_vld_s1;
	entry_t           rd_s1;
	logic [CNT_W-1:0] probes_q;
	logic [CNT_W-1:0] count_q;
	// slot memory
	entry_t           mem [SLOTS];
	logic             we;
	logic [IDX_W-1:0] wa;
	entry_t           wd;
	// result
	logic             done_q;
	response_t        resp_q;
	logic             eval;
	logic             hit;
	logic             miss;
	logic             early;
	logic             last;
	logic             is_ins;

	assign is_ins = (cmd_q == CMD_INSERT);
	assign scaled = PRD_W'(frac_s1) * PRD_W'(SLOTS);
	assign eval   = ctl.probe && rd_vld_s1;
	assign last   = (probes_q == CNT_LAST);
	assign early  = ctl.home &&
		((cmd_q != CMD_INSERT && cmd_q != CMD_SEARCH && cmd_q != CMD_DELETE) ||
		 (is_ins && count_q == CNT_FULL));

	always_comb begin
		hit  = 1'b0;
		miss = 1'b0;
		if (eval) begin
			if (is_ins) begin
				hit = (rd_s1.mark != MARK_USED);
			end else if (rd_s1.mark == MARK_EMPTY) begin
				miss = 1'b1;
			end else if (rd_s1.mark == MARK_USED && rd_s1.key == key_q) begin
				hit = 1'b1;
			end
		end
	end

	assign stat.clr_last = ctl.clr && (clr_ptr_q == LAST_IDX);
	assign stat.early    = early;
	assign stat.finish   = eval && (hit || miss || last);

	// memory write port: clearing pass or a probe hit that inserts or deletes
	always_comb begin
		we = 1'b0;
		wa = clr_ptr_q;
		wd = '{mark: MARK_EMPTY, key: key_q, payload: value_q};
		if (ctl.clr) begin
			we = 1'b1;
		end else if (hit) begin
			we = 1'b1;
			wa = eval_addr_s1;
			if (is_ins) begin
				wd = '{mark: MARK_USED, key: key_q, payload: value_q};
			end else if (cmd_q == CMD_DELETE) begin
				wd = '{mark: MARK_DELETED, key: rd_s1.key, payload: rd_s1.payload};
			end else begin
				we = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_s1 <= mem[ptr_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= req.command;
			key_q   <= req.key;
			value_q <= req.value;
		end
		if (ctl.hash) begin
			frac_s1 <= 32'({1'b0, key_q} * GOLDEN_Q32);
		end
		if (ctl.home) begin
			ptr_q <= scaled[32 +: IDX_W];
		end else if (ctl.probe) begin
			ptr_q <= (ptr_q == LAST_IDX) ? '0 : ptr_q + 1'b1;
		end
		eval_addr_s1 <= ptr_q;
		if (ctl.home) begin
			probes_q <= '0;
		end else if (eval) begin
			probes_q <= probes_q + 1'b1;
		end
		if (early) begin
			resp_q <= '{status: is_ins ? ST_FULL : ST_MISS, found_value: '0, slot_index: '0};
		end else if (hit) begin
			resp_q.status      <= ST_OK;
			resp_q.found_value <= is_ins ? 32'd0 : rd_s1.payload;
			resp_q.slot_index  <= 4'(eval_addr_s1);
		end else if (stat.finish) begin
			resp_q <= '{status: is_ins ? ST_FULL : ST_MISS, found_value: '0, slot_index: '0};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
			rd_vld_s1 <= 1'b0;
			count_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			if (ctl.clr) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
			end
			rd_vld_s1 <= ctl.probe;
			if (hit && is_ins) begin
				count_q <= count_q + 1'b1;
			end else if (hit && cmd_q == CMD_DELETE && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
			done_q <= early || stat.finish;
		end
	end

	assign done = done_q;
	assign resp = resp_q;

endmodule
`default_nettype wire

// ===== sv/open_addressing_hash_table_unit.sv =====
// Top level of the open-addressing hash table unit (linear probing).
// Sequence: start accepted, a hash step, a home-slot step, then probes at one slot
// per cycle after a registered memory read, at most SLOTS slots; done is registered
// from the deciding probe. Unused commands and a full-table insert finish without
// probing. One word in flight; busy stays high until done.
// Reset: asynchronous; then a clearing pass marks every slot empty with busy high.
// The receiver cannot stall: done strobes for one cycle.
`default_nettype none
module open_addressing_hash_table_unit
	import oaht_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire request_t request,
	output logic          done,
	output response_t     response
);

	ctl_cmd_t ctl;  // sequencing commands
	dp_stat_t stat; // outcome flags from the probe logic

	// state machine: clear pass, accept, hash, home, probe
	oaht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.stat   (stat)
	);

	// slot memory, hash arithmetic and the registered result word
	oaht_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (request),
		.stat   (stat),
		.done   (done),
		.resp   (response)
	);

endmodule
`default_nettype wire
